// ===== rtl/icacc_pkg.sv =====
// Shared constants, types and state encoding for the image centroid accumulator.
package icacc_pkg;

  localparam int MAX_WIDTH = 4096;

  localparam int PIX_W  = 16;
  localparam int WID_W  = 13;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 12;
  localparam int WSUM_W = 40;
  localparam int MOM_W  = 52;
  localparam int PROD_W = PIX_W + ((COL_W > ROW_W) ? COL_W : ROW_W);
  localparam int CEN_W  = 20;
  localparam int FRAC_W = 8;
  // Split point: moment bits above SPLIT form the first partial remainder of (moment << FRAC_W) / total.
  localparam int SPLIT  = CEN_W - FRAC_W;
  localparam int CNT_W  = $clog2(CEN_W);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_WIDTH = 1'b0;
  localparam logic [ADDR_W-3:0] REG_MASK  = 1'b1;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } icacc_state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic out_load;
  } icacc_cmd_t;

  typedef struct packed {
    logic out_free;
  } icacc_sts_t;

endpackage

// ===== rtl/icacc_regs.sv =====
// Configuration register file: image width and mask enable.
module icacc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [icacc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [icacc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [icacc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output logic [icacc_pkg::WID_W-1:0]   image_width,
  output logic                          use_mask
);
  import icacc_pkg::*;

  logic [WID_W-1:0]  width_r, width_nxt;
  logic              mask_r, mask_nxt;
  logic              wr_en;
  logic [ADDR_W-3:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];

  always_comb begin
    width_nxt = width_r;
    mask_nxt  = mask_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH: width_nxt = cfg_pwdata[WID_W-1:0];
        REG_MASK:  mask_nxt  = cfg_pwdata[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WID_W'(640);
      mask_r  <= 1'b0;
    end else begin
      width_r <= width_nxt;
      mask_r  <= mask_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH: cfg_prdata = {{(DATA_W-WID_W){1'b0}}, width_r};
      REG_MASK:  cfg_prdata = {{(DATA_W-1){1'b0}}, mask_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign image_width = width_r;
  assign use_mask    = mask_r;

endmodule

// ===== rtl/icacc_ctrl.sv =====
// Frame controller: pixel intake, pipeline drain, divider sequencing and result hand-off.
module icacc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tlast,
  output logic                  in_tready,
  output icacc_pkg::icacc_cmd_t cmd,
  input  icacc_pkg::icacc_sts_t sts
);
  import icacc_pkg::*;

  icacc_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic accept;

  assign in_tready = (state_r == ST_ACC);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC:    if (accept && in_tlast) state_nxt = ST_DRAIN1;
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == CNT_W'(CEN_W - 1)) state_nxt = ST_DONE;
      ST_DONE:   if (sts.out_free) state_nxt = ST_ACC;
      default:   state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.load     = (state_r == ST_LOAD);
    cmd.step     = (state_r == ST_DIV);
    cmd.out_load = (state_r == ST_DONE) && sts.out_free;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_LOAD) begin
      cnt_nxt = '0;
    end else if (state_r == ST_DIV) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/icacc_dp.sv =====
// Datapath: position counters, multiply-accumulate pipeline, radix-2 dividers, output word.
module icacc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  icacc_pkg::icacc_cmd_t       cmd,
  output icacc_pkg::icacc_sts_t       sts,
  input  logic [icacc_pkg::WID_W-1:0] image_width,
  input  logic                        use_mask,
  input  logic [icacc_pkg::PIX_W-1:0] pixel_value,
  input  logic                        mask_on,
  input  logic                        last_pixel,
  output logic [icacc_pkg::CEN_W-1:0] x_center,
  output logic [icacc_pkg::CEN_W-1:0] y_center,
  output logic                        weight_nonzero,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import icacc_pkg::*;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] eff_w;
  logic [WID_W-1:0] col_inc;

  // pipeline
  logic             s1_vld_r, s2_vld_r;
  logic [PIX_W-1:0] s1_w_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [PIX_W-1:0] s2_w_r;
  logic [PROD_W-1:0] s2_pc_r, s2_pr_r;

  // sums
  logic [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [MOM_W-1:0]  cmom_r, cmom_nxt;
  logic [MOM_W-1:0]  rmom_r, rmom_nxt;

  // dividers
  logic [WSUM_W-1:0] div_r;
  logic [WSUM_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [CEN_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [CEN_W-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic              satx_r, saty_r, nz_r;
  logic [WSUM_W:0]   tx, ty, tx_sub, ty_sub;
  logic              gex, gey;

  // output word
  logic              out_vld_r, out_vld_nxt;
  logic [CEN_W-1:0]  ox_r, oy_r;
  logic              onz_r;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WID_W'(1);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
  end

  assign col_inc = WID_W'(col_r) + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept) begin
      priority if (last_pixel) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= cmd.accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_w_r   <= (!use_mask || mask_on) ? pixel_value : '0;
    s1_col_r <= col_r;
    s1_row_r <= row_r;
    s2_w_r   <= s1_w_r;
    s2_pc_r  <= PROD_W'(s1_w_r) * PROD_W'(s1_col_r);
    s2_pr_r  <= PROD_W'(s1_w_r) * PROD_W'(s1_row_r);
  end

  always_comb begin
    wsum_nxt = wsum_r;
    cmom_nxt = cmom_r;
    rmom_nxt = rmom_r;
    priority if (cmd.load) begin
      wsum_nxt = '0;
      cmom_nxt = '0;
      rmom_nxt = '0;
    end else if (s2_vld_r) begin
      wsum_nxt = wsum_r + WSUM_W'(s2_w_r);
      cmom_nxt = cmom_r + MOM_W'(s2_pc_r);
      rmom_nxt = rmom_r + MOM_W'(s2_pr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
      cmom_r <= '0;
      rmom_r <= '0;
    end else begin
      wsum_r <= wsum_nxt;
      cmom_r <= cmom_nxt;
      rmom_r <= rmom_nxt;
    end
  end

  // one quotient bit per cycle; partial remainder stays below the divisor when it starts below it
  assign tx     = {rx_r, dx_r[CEN_W-1]};
  assign ty     = {ry_r, dy_r[CEN_W-1]};
  assign tx_sub = tx - {1'b0, div_r};
  assign ty_sub = ty - {1'b0, div_r};
  assign gex    = (tx >= {1'b0, div_r});
  assign gey    = (ty >= {1'b0, div_r});

  always_comb begin
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    qx_nxt = qx_r;
    qy_nxt = qy_r;
    priority if (cmd.load) begin
      rx_nxt = cmom_r[MOM_W-1:SPLIT];
      ry_nxt = rmom_r[MOM_W-1:SPLIT];
      dx_nxt = {cmom_r[SPLIT-1:0], {FRAC_W{1'b0}}};
      dy_nxt = {rmom_r[SPLIT-1:0], {FRAC_W{1'b0}}};
      qx_nxt = '0;
      qy_nxt = '0;
    end else if (cmd.step) begin
      rx_nxt = gex ? tx_sub[WSUM_W-1:0] : tx[WSUM_W-1:0];
      ry_nxt = gey ? ty_sub[WSUM_W-1:0] : ty[WSUM_W-1:0];
      dx_nxt = {dx_r[CEN_W-2:0], 1'b0};
      dy_nxt = {dy_r[CEN_W-2:0], 1'b0};
      qx_nxt = {qx_r[CEN_W-2:0], gex};
      qy_nxt = {qy_r[CEN_W-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    if (cmd.load) begin
      div_r  <= wsum_r;
      nz_r   <= (wsum_r != '0);
      satx_r <= (cmom_r[MOM_W-1:SPLIT] >= wsum_r);
      saty_r <= (rmom_r[MOM_W-1:SPLIT] >= wsum_r);
    end
  end

  assign sts.out_free = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    priority if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ox_r  <= !nz_r ? '0 : (satx_r ? '1 : qx_r);
      oy_r  <= !nz_r ? '0 : (saty_r ? '1 : qy_r);
      onz_r <= nz_r;
    end
  end

  assign x_center       = ox_r;
  assign y_center       = oy_r;
  assign weight_nonzero = onz_r;
  assign out_valid      = out_vld_r;

endmodule

// ===== rtl/image_centroid_accumulator.sv =====
// Top level of the intensity-weighted image centroid accumulator.
// Pixels are taken one per clock in raster order while a frame is open. The word
// carrying tlast closes the frame: after it the input stalls while the two
// multiply-accumulate pipeline stages drain, the divider is loaded, the shared
// radix-2 divider pair produces the quotients one bit per step and the result
// register is written, longer if the previous result has not yet been taken. The
// result word gives the centroid as 12.8 unsigned fixed point; tuser low means the
// total weight was zero and the centroid reads 0,0.
module image_centroid_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] pixel_value
  input  logic                          in_tuser,   // [0] mask_on
  input  logic                          in_tlast,   // last_pixel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [19:0] x_center, [39:20] y_center
  output logic                          out_tuser,  // [0] weight_nonzero
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [icacc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [icacc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [icacc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import icacc_pkg::*;

  icacc_cmd_t       cmd;
  icacc_sts_t       sts;
  logic [WID_W-1:0] image_width;
  logic             use_mask;
  logic [CEN_W-1:0] x_center, y_center;

  icacc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .image_width (image_width),
    .use_mask    (use_mask)
  );

  icacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  icacc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .image_width    (image_width),
    .use_mask       (use_mask),
    .pixel_value    (in_tdata[PIX_W-1:0]),
    .mask_on        (in_tuser),
    .last_pixel     (in_tlast),
    .x_center       (x_center),
    .y_center       (y_center),
    .weight_nonzero (out_tuser),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready)
  );

  assign out_tdata = {y_center, x_center};

endmodule

// ===== rtl/icacc_checker.sv =====
// Port-level checks for the centroid accumulator, bound to the top level.
module icacc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("zero total weight with nonzero centroid");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after frame end");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind image_centroid_accumulator icacc_checker u_icacc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/image_centroid_accumulator_test.sv =====
// Self-checking testbench for the intensity-weighted image centroid accumulator.
`timescale 1ns / 100ps

module image_centroid_accumulator_test;

  import icacc_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 16;

  typedef struct {
    logic [15:0] value;
    logic        mask;
    logic        last;
    logic        hold;
  } pixel_word_t;

  typedef struct {
    logic [19:0] x;
    logic [19:0] y;
    logic        nz;
  } centroid_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_tvalid    = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata     = '0;
  logic              in_tuser     = 1'b0;
  logic              in_tlast     = 1'b0;
  logic              out_tvalid;
  logic              out_tready   = 1'b0;
  logic [39:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_psel     = 1'b0;
  logic              cfg_penable  = 1'b0;
  logic              cfg_pwrite   = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr    = '0;
  logic [DATA_W-1:0] cfg_pwdata   = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // predictor state
  logic [12:0] cfg_width    = 13'd640;
  logic        cfg_use_mask = 1'b0;
  logic [39:0] weight_total   = '0;
  logic [51:0] col_moment_acc = '0;
  logic [51:0] row_moment_acc = '0;
  logic [11:0] col_idx        = '0;
  logic [11:0] row_idx        = '0;

  pixel_word_t pixel_fifo[$];
  centroid_t   pending_centroids[$];
  pixel_word_t next_word;
  centroid_t   got_expected;

  logic in_taken      = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   stall_cycles   = 0;
  int   error_count    = 0;

  int phase_width [PHASES] = '{1, 2, 3, 5, 8, 13, 16, 0, 4096, 8191, 31, 640, 4097, 2, 7, 3};

  image_centroid_accumulator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [19:0] scaled_centroid(logic [51:0] moment, logic [39:0] total);
    logic [63:0] q;
    q = {4'b0, moment, 8'b0} / {24'b0, total};
    return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
  endfunction

  task automatic note_mismatch(input string what);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", what);
  endtask

  task automatic accumulate_pixel(input logic [15:0] pix, input logic mask, input logic last);
    int        eff;
    centroid_t c;
    if (!cfg_use_mask || mask) begin
      weight_total   = weight_total + pix;
      col_moment_acc = col_moment_acc + pix * col_idx;
      row_moment_acc = row_moment_acc + pix * row_idx;
    end
    eff = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    if (int'(col_idx) + 1 >= eff) begin
      col_idx = '0;
      row_idx = row_idx + 1'b1;
    end else begin
      col_idx = col_idx + 1'b1;
    end
    if (last) begin
      if (weight_total != 0) begin
        c.x  = scaled_centroid(col_moment_acc, weight_total);
        c.y  = scaled_centroid(row_moment_acc, weight_total);
        c.nz = 1'b1;
      end else begin
        c.x  = '0;
        c.y  = '0;
        c.nz = 1'b0;
      end
      pending_centroids.push_back(c);
      weight_total   = '0;
      col_moment_acc = '0;
      row_moment_acc = '0;
      col_idx        = '0;
      row_idx        = '0;
    end
  endtask

  // monitor, predictor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) accumulate_pixel(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (pending_centroids.size() == 0) begin
          note_mismatch($sformatf("unexpected word x=%h y=%h nz=%b",
                                  out_tdata[19:0], out_tdata[39:20], out_tuser));
        end else begin
          got_expected = pending_centroids.pop_front();
          if (out_tdata[19:0] !== got_expected.x || out_tdata[39:20] !== got_expected.y ||
              out_tuser !== got_expected.nz)
            note_mismatch($sformatf("expected x=%h y=%h nz=%b, got x=%h y=%h nz=%b",
                                    got_expected.x, got_expected.y, got_expected.nz,
                                    out_tdata[19:0], out_tdata[39:20], out_tuser));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pixel_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pixel_fifo[0].hold && pending_centroids.size() != 0)) begin
        next_word = pixel_fifo.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_word.value;
        in_tuser  <= next_word.mask;
        in_tlast  <= next_word.last;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 16'($urandom);
        in_tuser  <= 1'($urandom);
        in_tlast  <= 1'($urandom);
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_register(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    apb_xfer(1'b1, {idx, 2'b00}, value, rd);
    if (idx == REG_WIDTH) begin
      cfg_width = value[12:0];
      want      = DATA_W'(cfg_width);
    end else begin
      cfg_use_mask = value[0];
      want         = DATA_W'(cfg_use_mask);
    end
    apb_xfer(1'b0, {idx, 2'b00}, $urandom, rd);
    if (rd !== want)
      note_mismatch($sformatf("register %0d expected %h, read %h", idx, want, rd));
  endtask

  task automatic write_width(input int w);
    set_register(REG_WIDTH, ($urandom & ~32'h1FFF) | w);
  endtask

  task automatic write_use_mask(input logic m);
    set_register(REG_MASK, ($urandom & ~32'h1) | m);
  endtask

  task automatic begin_phase(input int mode);
    @(posedge clk);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  task automatic push_pixel(input logic [15:0] v, input logic m, input logic l, input logic h);
    pixel_word_t pw;
    pw.value = v;
    pw.mask  = m;
    pw.last  = l;
    pw.hold  = h;
    pixel_fifo.push_back(pw);
  endtask

  // all words taken, all results in, then let the divider settle
  task automatic wait_quiet();
    int n;
    do @(posedge clk); while (pixel_fifo.size() != 0 || in_tvalid);
    do @(negedge clk); while (pending_centroids.size() != 0);
    for (n = 0; n < SETTLE_CYCLES; n++) @(negedge clk);
  endtask

  function automatic logic [15:0] random_pixel();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int p, k, len, eff, items, extra;
    logic hold;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset config: width 640, mask ignored
    begin_phase(0);
    push_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0);
    push_pixel(16'h0000, 1'b1, 1'b0, 1'b0);
    push_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0);
    push_pixel(16'h0001, 1'b1, 1'b1, 1'b0);
    wait_quiet();

    write_width(3);
    write_use_mask(1'b0);
    begin_phase(3);
    push_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0);
    push_pixel(16'h0000, 1'b1, 1'b0, 1'b0);
    push_pixel(16'h0001, 1'b1, 1'b0, 1'b0);
    push_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_pixel(16'h0002, 1'b0, 1'b0, 1'b0);
    push_pixel(16'hFFFF, 1'b1, 1'b1, 1'b0);
    // zero total weight
    push_pixel(16'h0000, 1'b1, 1'b1, 1'b1);
    wait_quiet();

    write_use_mask(1'b1);
    begin_phase(2);
    // last pixel masked off
    push_pixel(16'd100,   1'b1, 1'b0, 1'b0);
    push_pixel(16'd200,   1'b0, 1'b0, 1'b0);
    push_pixel(16'hFFFF,  1'b1, 1'b0, 1'b0);
    push_pixel(16'd300,   1'b0, 1'b1, 1'b0);
    // everything masked: zero weight
    push_pixel(16'd5000,  1'b0, 1'b0, 1'b0);
    push_pixel(16'hFFFF,  1'b0, 1'b1, 1'b0);
    wait_quiet();

    // width 0 behaves as 1
    write_width(0);
    begin_phase(1);
    push_pixel(16'd10, 1'b1, 1'b0, 1'b0);
    push_pixel(16'd20, 1'b1, 1'b0, 1'b0);
    push_pixel(16'd30, 1'b1, 1'b1, 1'b0);
    wait_quiet();

    // width above the maximum clamps
    write_width(8191);
    begin_phase(0);
    push_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_pixel(16'hFFFF, 1'b1, 1'b1, 1'b0);
    wait_quiet();

    for (p = 0; p < PHASES; p++) begin
      write_width(phase_width[p]);
      write_use_mask((p % 3 == 2) ? 1'b1 : 1'($urandom_range(1)));
      begin_phase(p % 4);
      eff = (phase_width[p] == 0) ? 1 :
            ((phase_width[p] > MAX_WIDTH) ? MAX_WIDTH : phase_width[p]);
      items = 0;
      while (items < 112) begin
        case ($urandom_range(9))
          0:       len = 1;
          8, 9:    len = $urandom_range(200, 1);
          default: len = $urandom_range((4 * eff > 48) ? 48 : 4 * eff, 1);
        endcase
        if (len > 112 - items) len = 112 - items;
        hold = ($urandom_range(29) == 0);
        for (k = 0; k < len; k++)
          push_pixel(random_pixel(), $urandom_range(9) < 7, k == len - 1, hold && k == 0);
        items += len;
      end
      // leave a frame open so the next width applies mid-frame
      if (p % 3 == 1) begin
        extra = $urandom_range(20, 3);
        for (k = 0; k < extra; k++) push_pixel(random_pixel(), $urandom_range(9) < 7, 1'b0, 1'b0);
      end
      wait_quiet();
    end

    if (pending_centroids.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_centroids.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/icacc_pkg.sv
rtl/icacc_regs.sv
rtl/icacc_ctrl.sv
rtl/icacc_dp.sv
rtl/image_centroid_accumulator.sv
rtl/icacc_checker.sv
sim/image_centroid_accumulator_test.sv
